>>> src/b45d_pkg.sv
// Shared types, status codes and the character-to-digit table of the Base45 decoder.
`timescale 1ns / 1ps
`default_nettype none

package b45d_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_BIGVAL  = 2'd2;
  localparam logic [1:0] ST_BADLEN  = 2'd3;

  localparam logic [5:0] DIGIT_BAD = 6'd45;

  // One decoded event handed from the front to the back.
  typedef struct packed {
    logic [7:0] hi_byte;   // first byte of a triple
    logic [7:0] lo_byte;   // only byte of a pair, second byte of a triple
    logic       two_bytes; // triple: emit hi_byte then lo_byte
    logic [1:0] status;
    logic       msg_last;
  } evt_t;

  // Map an ASCII code to its digit, DIGIT_BAD outside the alphabet.
  function automatic logic [5:0] b45_digit(input logic [7:0] ch);
    logic [5:0] d;
    d = DIGIT_BAD;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = 6'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = 6'(ch - 8'h41 + 8'd10);
    end else begin
      unique case (ch)
        8'h20:   d = 6'd36; // space
        8'h24:   d = 6'd37; // $
        8'h25:   d = 6'd38; // %
        8'h2A:   d = 6'd39; // *
        8'h2B:   d = 6'd40; // +
        8'h2D:   d = 6'd41; // -
        8'h2E:   d = 6'd42; // .
        8'h2F:   d = 6'd43; // /
        8'h3A:   d = 6'd44; // :
        default: d = DIGIT_BAD;
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> src/base45_decoder.sv
// Top level of the Base45 decoder: front end, event queue and back end.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_char_i, msg_end_i
//   out     | output    | out_valid_o/out_ready_i| out_byte_o, status_o, run_last_o,
//           |           |                        | msg_last_o
//
// Flow: the front takes one character per cycle while in_ready_o is high and
// classifies it in that same cycle; a completed group is written into the queue
// at the edge that takes its last character and then waits there until the back
// loads it. The back emits one output word per cycle while out_ready_i is high
// and the queue holds events; a triple gives two words, a pair or an error one.
// Reset: rst_ni is asynchronous, active low, and clears group state, queue
// pointers and the output valid.
// Stalls: in_ready_o drops only while the event queue is full; the back stalls
// on out_ready_i alone and holds its output word until taken.
`timescale 1ns / 1ps
`default_nettype none

module base45_decoder import b45d_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       msg_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            run_last_o,
  output logic            msg_last_o
);

  evt_t evt, head;
  logic evt_push, q_full, q_empty, q_pop;
  logic accept;

  // Take a character whenever the queue has room for the event it may cause.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  b45d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_char_i  (in_char_i),
    .msg_end_i  (msg_end_i),
    .evt_o      (evt),
    .evt_push_o (evt_push)
  );

  // Decouple the front (at most one event per character) from the back (one byte per cycle unless stalled).
  b45d_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (evt_push),
    .push_data_i (evt),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head),
    .empty_o     (q_empty)
  );

  b45d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o),
    .msg_last_o  (msg_last_o)
  );

endmodule

`default_nettype wire

>>> src/b45d_front.sv
// Front end: classify each character and build up digit groups into events.
`timescale 1ns / 1ps
`default_nettype none

module b45d_front import b45d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       msg_end_i,
  output evt_t            evt_o,
  output logic            evt_push_o
);

  logic [1:0]  count_q, count_d;
  logic [10:0] partial_q, partial_d;
  logic        discard_q, discard_d;

  logic [5:0]  digit;
  logic [1:0]  count_eff;
  logic [10:0] partial_eff;
  logic [11:0] pair_val;
  logic [16:0] trip_val;

  assign digit       = b45_digit(in_char_i);
  assign count_eff   = (count_q == 2'd1 || count_q == 2'd2) ? count_q : 2'd0;
  assign partial_eff = (count_eff == 2'd0) ? 11'd0 : partial_q;
  assign pair_val    = 12'(partial_eff) + 12'(digit) * 12'd45;
  assign trip_val    = 17'(partial_eff) + 17'(digit) * 17'd2025;

  always_comb begin
    count_d    = count_q;
    partial_d  = partial_q;
    discard_d  = discard_q;
    evt_push_o = 1'b0;
    evt_o      = '0;
    if (accept_i) begin
      if (discard_q) begin
        // Drop characters until the message ends.
        if (msg_end_i) begin
          discard_d = 1'b0;
          count_d   = 2'd0;
          partial_d = '0;
        end
      end else begin
        count_d   = 2'd0;
        partial_d = '0;
        if (count_eff == 2'd0 && msg_end_i) begin
          evt_push_o     = 1'b1;
          evt_o.status   = ST_BADLEN;
          evt_o.msg_last = 1'b1;
        end else if (digit == DIGIT_BAD) begin
          evt_push_o     = 1'b1;
          evt_o.status   = ST_BADCHAR;
          evt_o.msg_last = 1'b1;
          discard_d      = !msg_end_i;
        end else if (count_eff == 2'd0) begin
          partial_d = 11'(digit);
          count_d   = 2'd1;
        end else if (count_eff == 2'd1) begin
          if (!msg_end_i) begin
            partial_d = pair_val[10:0];
            count_d   = 2'd2;
          end else if (pair_val > 12'd255) begin
            evt_push_o     = 1'b1;
            evt_o.status   = ST_BIGVAL;
            evt_o.msg_last = 1'b1;
          end else begin
            evt_push_o     = 1'b1;
            evt_o.lo_byte  = pair_val[7:0];
            evt_o.status   = ST_OK;
            evt_o.msg_last = 1'b1;
          end
        end else begin
          if (trip_val[16]) begin
            evt_push_o     = 1'b1;
            evt_o.status   = ST_BIGVAL;
            evt_o.msg_last = 1'b1;
            discard_d      = !msg_end_i;
          end else begin
            evt_push_o      = 1'b1;
            evt_o.hi_byte   = trip_val[15:8];
            evt_o.lo_byte   = trip_val[7:0];
            evt_o.two_bytes = 1'b1;
            evt_o.status    = ST_OK;
            evt_o.msg_last  = msg_end_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 2'd0;
      partial_q <= '0;
      discard_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      partial_q <= partial_d;
      discard_q <= discard_d;
    end
  end

endmodule

`default_nettype wire

>>> src/b45d_fifo.sv
// Small event queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module b45d_fifo import b45d_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire evt_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output evt_t      head_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  evt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/b45d_back.sv
// Back end: expand queued events into output words held in an output register.
`timescale 1ns / 1ps
`default_nettype none

module b45d_back import b45d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire evt_t       head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            run_last_o,
  output logic            msg_last_o
);

  logic       valid_q, valid_d;
  logic       second_q, second_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       rl_q, rl_d;
  logic       ml_q, ml_d;
  logic       load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    byte_d   = byte_q;
    status_d = status_q;
    rl_d     = rl_q;
    ml_d     = ml_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.two_bytes && !second_q) begin
          // High byte of a triple; keep the entry for the low byte.
          byte_d   = head_i.hi_byte;
          status_d = ST_OK;
          rl_d     = 1'b0;
          ml_d     = 1'b0;
          second_d = 1'b1;
        end else begin
          byte_d   = head_i.lo_byte;
          status_d = head_i.status;
          rl_d     = 1'b1;
          ml_d     = head_i.msg_last;
          second_d = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    status_q <= status_d;
    rl_q     <= rl_d;
    ml_q     <= ml_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign run_last_o  = rl_q;
  assign msg_last_o  = ml_q;

endmodule

`default_nettype wire

>>> src/b45d_checker.sv
// Port-level checks of the Base45 decoder output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module b45d_checker import b45d_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] status_o,
  input wire logic       run_last_o,
  input wire logic       msg_last_o
);

  // An error word is alone: zero byte, ends its run and its message.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> run_last_o && msg_last_o && out_byte_o == 8'd0)
    else $error("error word malformed");

  // The first byte of a triple is never an error nor a message end.
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> status_o == ST_OK && !msg_last_o)
    else $error("first byte of triple malformed");

  // Once the first byte of a triple is taken, the second byte follows in the very next cycle.
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o && run_last_o)
    else $error("second byte of triple missing");

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(status_o) && $stable(run_last_o) && $stable(msg_last_o))
    else $error("stalled output word changed");

endmodule

bind base45_decoder b45d_checker u_b45d_checker (.*);

`default_nettype wire

>>> tb/sv/base45_decoder_checker.sv
// Output checker of the Base45 decoder: predicts every output word and compares it.
`timescale 1ns / 1ps

module base45_decoder_checker import b45d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       msg_end_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic [1:0] status_i,
  input  wire logic       run_last_i,
  input  wire logic       msg_last_i,
  output int unsigned     fail_count_o,
  output int unsigned     words_due_o
);

  localparam string Alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
  localparam int unsigned NoDigit = 45;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       run_last;
    logic       msg_last;
  } word_t;

  word_t       words_due[$];
  logic [1:0]  digits_held;
  logic [10:0] group_value;
  logic        discarding;
  int unsigned fails;

  function automatic int unsigned digit_of(input logic [7:0] ch);
    int unsigned d;
    d = NoDigit;
    for (int k = 0; k < 45; k++) begin
      if (Alphabet[k] == ch) d = k;
    end
    return d;
  endfunction

  task automatic add_due(input logic [7:0] data, input logic [1:0] st, input logic rl,
                         input logic ml);
    word_t w;
    w.data = data;
    w.status = st;
    w.run_last = rl;
    w.msg_last = ml;
    words_due.push_back(w);
  endtask

  // An error gives one word and skips the rest of the message unless it is the end.
  task automatic flag_error(input logic [1:0] st, input logic last);
    digits_held = '0;
    group_value = '0;
    discarding = !last;
    add_due(8'h00, st, 1'b1, 1'b1);
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic last);
    int unsigned d;
    int unsigned v;
    if (discarding) begin
      if (last) begin
        discarding = 1'b0;
        digits_held = '0;
        group_value = '0;
      end
      return;
    end
    if (digits_held != 2'd1 && digits_held != 2'd2) begin
      digits_held = '0;
      group_value = '0;
      if (last) begin
        flag_error(ST_BADLEN, 1'b1);
        return;
      end
    end
    d = digit_of(ch);
    if (d == NoDigit) begin
      flag_error(ST_BADCHAR, last);
      return;
    end
    case (digits_held)
      2'd0: begin
        group_value = 11'(d);
        digits_held = 2'd1;
      end
      2'd1: begin
        v = group_value + d * 45;
        if (!last) begin
          group_value = 11'(v);
          digits_held = 2'd2;
        end else if (v > 255) begin
          flag_error(ST_BIGVAL, 1'b1);
        end else begin
          digits_held = '0;
          group_value = '0;
          add_due(8'(v), ST_OK, 1'b1, 1'b1);
        end
      end
      default: begin
        v = group_value + d * 2025;
        if (v > 65535) begin
          flag_error(ST_BIGVAL, last);
        end else begin
          digits_held = '0;
          group_value = '0;
          add_due(8'(v >> 8), ST_OK, 1'b0, 1'b0);
          add_due(8'(v), ST_OK, 1'b1, last);
        end
      end
    endcase
  endtask

  task automatic compare_word(input word_t got);
    word_t want;
    if (words_due.size() == 0) begin
      $error("unexpected word: out_byte %0h status %0d run_last %0b msg_last %0b",
             got.data, got.status, got.run_last, got.msg_last);
      fails++;
      return;
    end
    want = words_due.pop_front();
    if (got.data !== want.data) begin
      $error("out_byte: expected %0h, got %0h", want.data, got.data);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fails++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
      fails++;
    end
    if (got.msg_last !== want.msg_last) begin
      $error("msg_last: expected %0b, got %0b", want.msg_last, got.msg_last);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_held = '0;
      group_value = '0;
      discarding = 1'b0;
      fails = 0;
      words_due.delete();
      fail_count_o <= 0;
      words_due_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_char(in_char_i, msg_end_i);
      if (out_valid_i && out_ready_i) begin
        compare_word({out_byte_i, status_i, run_last_i, msg_last_i});
      end
      fail_count_o <= fails;
      words_due_o <= words_due.size();
    end
  end

endmodule

>>> tb/sv/base45_decoder_tb.sv
// Testbench top of the Base45 decoder: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module base45_decoder_tb;

  localparam string Alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
  localparam int unsigned CharsTarget = 1600;  // random characters after the directed part
  localparam int unsigned StallLimit  = 2000;  // cycles with no handshake on either channel
  localparam int unsigned DrainCycles = 20;    // margin for stray words after the last expected word

  typedef logic [7:0] text_t[$];

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i = 8'h00;
  logic       msg_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_last_o;
  logic       msg_last_o;

  int unsigned fail_count;
  int unsigned words_due;
  int unsigned chars_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 87;

  // Idle rates per random phase: sender, then receiver; the last phase runs flat out.
  int unsigned send_pcts[3] = '{14, 87, 0};
  int unsigned recv_pcts[3] = '{87, 14, 0};

  base45_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .msg_end_i   (msg_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o),
    .msg_last_o  (msg_last_o)
  );

  base45_decoder_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_char_i    (in_char_i),
    .msg_end_i    (msg_end_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_i   (out_byte_o),
    .status_i     (status_o),
    .run_last_i   (run_last_o),
    .msg_last_i   (msg_last_o),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the output channel at random; one update per falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles in which no word moves on either channel; give up past the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL base45_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic text_t chars_of(input string s);
    text_t q;
    for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    return q;
  endfunction

  // Drive one input word at a falling edge and hold it until the block takes it.
  // Idle cycles before it carry garbage on the payload with valid low.
  task automatic send_word(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_char_i <= 8'($urandom);
      msg_end_i <= 1'($urandom);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_char_i <= ch;
    msg_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  // Send a whole message; the last character carries the end flag.
  task automatic send_msg(input text_t msg);
    for (int k = 0; k < msg.size(); k++) send_word(msg[k], k == msg.size() - 1);
  endtask

  // Build one random message: mostly proper Base45 of random bytes, the rest
  // corrupted encodings, raw alphabet digits and plain noise.
  task automatic send_random_msg();
    text_t msg;
    logic [7:0] raw[$];
    int unsigned kind;
    int unsigned n;
    int unsigned v;
    kind = $urandom_range(99);
    n = $urandom_range(1, 12);
    if (kind < 80) begin
      for (int k = 0; k < n; k++) raw.push_back(8'($urandom));
      for (int k = 0; k < n; k += 2) begin
        if (k + 1 < n) begin
          v = raw[k] * 256 + raw[k + 1];
          msg.push_back(Alphabet[v % 45]);
          msg.push_back(Alphabet[(v / 45) % 45]);
          msg.push_back(Alphabet[v / 2025]);
        end else begin
          v = raw[k];
          msg.push_back(Alphabet[v % 45]);
          msg.push_back(Alphabet[v / 45]);
        end
      end
      // Corrupt one position now and then.
      if (kind >= 70) msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
    end else if (kind < 90) begin
      for (int k = 0; k < n; k++) msg.push_back(Alphabet[$urandom_range(44)]);
    end else begin
      for (int k = 0; k < n; k++) msg.push_back(8'($urandom));
    end
    send_msg(msg);
  endtask

  initial begin
    text_t msg;
    int unsigned chars_base;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: largest triple then a zero pair, largest pair, pair one too large.
    send_msg(chars_of("FGW00"));
    send_msg(chars_of("U5"));
    send_msg(chars_of("V5"));
    // Triple one too large mid-message: drop the rest up to the end flag.
    send_msg(chars_of("GGWZ"));
    // Zero triple, then a lone final character.
    send_msg(chars_of("000A"));
    // Lone final character outside the alphabet still reports bad length.
    msg = {8'hFF};
    send_msg(msg);
    // Bad character on the final word: no discarding afterwards.
    msg = chars_of("1");
    msg.push_back(8'h00);
    send_msg(msg);
    // Lowercase is not in the alphabet; the end flag clears the discard.
    send_msg(chars_of("a:"));
    // Largest digits in a final triple.
    send_msg(chars_of(":::"));

    // Random part in three idling phases.
    chars_base = chars_sent;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      while (chars_sent < chars_base + (p + 1) * CharsTarget / 3) send_random_msg();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait out the outstanding words, then give the block time to misbehave.
    while (words_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS base45_decoder");
    end else begin
      $display("FAIL base45_decoder");
    end
    $finish;
  end

endmodule
